[src/bilinear_pixel_interpolator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Bilinear pixel interpolator assertion macros
// Shared concurrent assertion forms for the interpolator pipeline.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_PIXEL_INTERPOLATOR_UNIT_ASSERT_SVH
`define BILINEAR_PIXEL_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BPI_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define BPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bpi_pkg.sv]
// ----------------------------------------------------------------------------
// Bilinear pixel interpolator package
// Shared types, register indexes and channel helpers.
// ----------------------------------------------------------------------------
package bpi_pkg;

   localparam int MAX_SOURCE_DIM = 4096;
   localparam int PIX_W          = 32;
   localparam int POS_W          = 28;
   localparam int DIM_W          = 13;
   localparam int CH_W           = 8;
   localparam int NUM_CH         = 3;
   localparam int REQ_W          = 4 * PIX_W + 2 * POS_W;
   localparam int RSP_W          = PIX_W;
   localparam int CSR_IDX_W      = 2;

   localparam logic [DIM_W-1:0] SOURCE_DIM_RESET = DIM_W'(MAX_SOURCE_DIM % 8192);

   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd2;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef logic [NUM_CH-1:0][CH_W-1:0] chan_vec_type;

   typedef struct packed {
      logic [POS_W-1:0] y_position;
      logic [POS_W-1:0] x_position;
      logic [PIX_W-1:0] bottom_right;
      logic [PIX_W-1:0] bottom_left;
      logic [PIX_W-1:0] top_right;
      logic [PIX_W-1:0] top_left;
   } req_type;

   typedef struct packed {
      logic             wide;
      logic [DIM_W-1:0] source_width;
      logic [DIM_W-1:0] source_height;
   } cfg_type;

   typedef struct packed {
      logic             wide;
      logic             at_edge;
      logic [PIX_W-1:0] top_left;
      chan_vec_type     tl_ch;
      chan_vec_type     tr_ch;
      chan_vec_type     bl_ch;
      chan_vec_type     br_ch;
      logic [CH_W-1:0]  fx;
      logic [CH_W-1:0]  fy;
   } s1_type;

   typedef struct packed {
      logic             wide;
      logic             at_edge;
      logic [PIX_W-1:0] top_left;
      chan_vec_type     top;
      chan_vec_type     bot;
      logic [CH_W-1:0]  fy;
   } s2_type;

   function automatic logic [CH_W-1:0] chan_extract(input logic [PIX_W-1:0] p,
                                                    input logic [1:0] k,
                                                    input logic wide);
      logic [CH_W-1:0] c;
      if (wide) begin
         unique case (k)
            CH_RED:   c = p[23:16];
            CH_GREEN: c = p[15:8];
            default:  c = p[7:0];
         endcase
      end else begin
         unique case (k)
            CH_RED:   c = {p[15:11], 3'b000};
            CH_GREEN: c = {p[10:5], 2'b00};
            default:  c = {p[4:0], 3'b000};
         endcase
      end
      return c;
   endfunction

   // (a*(256-w) + b*w) >> 8; the sum stays below 2^16
   function automatic logic [CH_W-1:0] blend8(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b,
                                              input logic [CH_W-1:0] w);
      logic [8:0]  wa;
      logic [16:0] sum;
      wa  = 9'd256 - {1'b0, w};
      sum = 17'({1'b0, a} * {8'b0, wa}) + 17'({1'b0, b} * {9'b0, w});
      return sum[15:8];
   endfunction

endpackage

[src/bilinear_pixel_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// Bilinear pixel interpolator unit
// Filters one pixel from a 2x2 source block and a 12.16 position.
// ----------------------------------------------------------------------------
// req_ carries one beat per output pixel: four neighbor pixels and the x and
// y positions. rsp_ returns one filtered pixel per request beat, in order.
// csr_ writes pixel format and source size; write it only while idle.
// Three register stages: decode and edge test, horizontal blend, vertical
// blend and repack into the result register. A new beat is taken every
// cycle while rsp_tready is high.
// When rsp_tready is low the stages fill up and hold; req_tready drops only
// once all three stages hold a beat, and no beat is lost or repeated.
// Reset empties the pipeline and sets ARGB8888 with a 4096 x 4096 source.
// ----------------------------------------------------------------------------
`include "bilinear_pixel_interpolator_unit_assert.svh"

module bilinear_pixel_interpolator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // top_left, top_right, bottom_left, bottom_right, x_position, y_position
   input  logic [bpi_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // filtered_pixel
   output logic [bpi_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [bpi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpi_pkg::DIM_W-1:0]     csr_wdata
);
   import bpi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   req_type req_data;
   logic    s1_valid;
   s1_type  s1_data;
   logic    s1_ready;
   logic    s2_valid;
   s2_type  s2_data;
   logic    s2_ready;

   assign req_data = req_type'(req_tdata);

   always_comb begin
      cfg_in = cfg_ff;
      unique case (csr_index)
         CSR_PIXEL_FORMAT:  cfg_in.wide          = csr_wdata[0];
         CSR_SOURCE_WIDTH:  cfg_in.source_width  = csr_wdata;
         CSR_SOURCE_HEIGHT: cfg_in.source_height = csr_wdata;
         default:           cfg_in               = cfg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wide          <= 1'b1;
         cfg_ff.source_width  <= SOURCE_DIM_RESET;
         cfg_ff.source_height <= SOURCE_DIM_RESET;
      end else if (csr_wr_en) begin
         cfg_ff <= cfg_in;
      end
   end

   bpi_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_data   (req_data),
      .in_ready  (req_tready),
      .out_valid (s1_valid),
      .out_data  (s1_data),
      .out_ready (s1_ready)
   );

   bpi_hblend u_hblend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .in_ready  (s1_ready),
      .out_valid (s2_valid),
      .out_data  (s2_data),
      .out_ready (s2_ready)
   );

   bpi_vblend u_vblend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .in_ready  (s2_ready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_ready (rsp_tready)
   );

   `BPI_ASSERT_IMPLIES(a_ready_only_when_full, clock, reset, !req_tready,
      s1_valid && s2_valid && rsp_tvalid && !rsp_tready,
      "request stalled while the pipeline had room")

   `BPI_ASSERT_NEXT(a_result_follows_drain, clock, reset,
      s2_valid && s2_ready, rsp_tvalid, "vertical stage dropped a beat")

endmodule

[src/bpi_unpack.sv]
// ----------------------------------------------------------------------------
// Bilinear pixel interpolator, decode stage
// Edge test, channel expansion and weight extraction.
// ----------------------------------------------------------------------------
`include "bilinear_pixel_interpolator_unit_assert.svh"

module bpi_unpack (
   input  logic              clock,
   input  logic              reset,
   input  bpi_pkg::cfg_type  cfg,
   input  logic              in_valid,
   input  bpi_pkg::req_type  in_data,
   output logic              in_ready,
   output logic              out_valid,
   output bpi_pkg::s1_type   out_data,
   input  logic              out_ready
);
   import bpi_pkg::*;

   logic             valid_ff;
   s1_type           data_ff;
   s1_type           data_in;
   logic [DIM_W-1:0] x_next;
   logic [DIM_W-1:0] y_next;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      x_next           = {1'b0, in_data.x_position[POS_W-1:16]} + DIM_W'(1);
      y_next           = {1'b0, in_data.y_position[POS_W-1:16]} + DIM_W'(1);
      data_in.wide     = cfg.wide;
      data_in.at_edge  = (x_next >= cfg.source_width) || (y_next >= cfg.source_height);
      data_in.top_left = in_data.top_left;
      data_in.fx       = in_data.x_position[15:8];
      data_in.fy       = in_data.y_position[15:8];
      for (int k = 0; k < NUM_CH; k++) begin
         data_in.tl_ch[k] = chan_extract(in_data.top_left, 2'(k), cfg.wide);
         data_in.tr_ch[k] = chan_extract(in_data.top_right, 2'(k), cfg.wide);
         data_in.bl_ch[k] = chan_extract(in_data.bottom_left, 2'(k), cfg.wide);
         data_in.br_ch[k] = chan_extract(in_data.bottom_right, 2'(k), cfg.wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   `BPI_ASSERT_NEXT(a_unpack_hold, clock, reset, valid_ff && !out_ready,
      valid_ff && $stable(data_ff), "decode stage lost or changed a stalled beat")

endmodule

[src/bpi_hblend.sv]
// ----------------------------------------------------------------------------
// Bilinear pixel interpolator, horizontal stage
// Blend top and bottom pixel pairs with the x weight.
// ----------------------------------------------------------------------------
`include "bilinear_pixel_interpolator_unit_assert.svh"

module bpi_hblend (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  bpi_pkg::s1_type  in_data,
   output logic             in_ready,
   output logic             out_valid,
   output bpi_pkg::s2_type  out_data,
   input  logic             out_ready
);
   import bpi_pkg::*;

   logic   valid_ff;
   s2_type data_ff;
   s2_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.wide     = in_data.wide;
      data_in.at_edge  = in_data.at_edge;
      data_in.top_left = in_data.top_left;
      data_in.fy       = in_data.fy;
      for (int k = 0; k < NUM_CH; k++) begin
         data_in.top[k] = blend8(in_data.tl_ch[k], in_data.tr_ch[k], in_data.fx);
         data_in.bot[k] = blend8(in_data.bl_ch[k], in_data.br_ch[k], in_data.fx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   `BPI_ASSERT_NEXT(a_hblend_hold, clock, reset, valid_ff && !out_ready,
      valid_ff && $stable(data_ff), "horizontal stage lost or changed a stalled beat")

endmodule

[src/bpi_vblend.sv]
// ----------------------------------------------------------------------------
// Bilinear pixel interpolator, vertical stage
// Blend with the y weight, repack and hold the result beat.
// ----------------------------------------------------------------------------
module bpi_vblend (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  bpi_pkg::s2_type          in_data,
   output logic                     in_ready,
   output logic                     out_valid,
   output logic [bpi_pkg::RSP_W-1:0] out_data,
   input  logic                     out_ready
);
   import bpi_pkg::*;

   logic             valid_ff;
   logic [RSP_W-1:0] data_ff;
   logic [RSP_W-1:0] data_in;
   chan_vec_type     c;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         c[k] = blend8(in_data.top[k], in_data.bot[k], in_data.fy);
      end
      priority if (in_data.at_edge && in_data.wide) begin
         data_in = in_data.top_left;
      end else if (in_data.at_edge) begin
         data_in = {16'h0000, in_data.top_left[15:0]};
      end else if (in_data.wide) begin
         data_in = {in_data.top_left[31:24], c[CH_RED], c[CH_GREEN], c[CH_BLUE]};
      end else begin
         data_in = {16'h0000, c[CH_RED][7:3], c[CH_GREEN][7:2], c[CH_BLUE][7:3]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
